FILE: src/slt_pkg.sv
// shared constants, types and state codes of the sorted linked table
package slt_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
  localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W      = 32;

  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOT_COUNT);

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_LINK1,
    ST_LINK2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    key_we;
    logic [SLOT_W-1:0]       key_addr;
    logic signed [KEY_W-1:0] key_data;
    logic                    link_we;
    logic [SLOT_W-1:0]       link_addr;
    logic [LINK_W-1:0]       link_data;
  } wr_req_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] s);
    return s < NO_SLOT;
  endfunction

endpackage

FILE: src/slt_store.sv
// key and link memories with one registered read port and one write port each
module slt_store (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [slt_pkg::SLOT_W-1:0]              rd_addr,
  input  slt_pkg::wr_req_t                        wr,
  output logic signed [slt_pkg::KEY_W-1:0]        key_q,
  output logic [slt_pkg::LINK_W-1:0]              link_q
);

  logic signed [slt_pkg::KEY_W-1:0] key_mem  [slt_pkg::SLOT_COUNT];
  logic [slt_pkg::LINK_W-1:0]       link_mem [slt_pkg::SLOT_COUNT];
  logic [slt_pkg::SLOT_COUNT-1:0]   link_ok;

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.key_addr] <= wr.key_data;
    end
    if (wr.link_we) begin
      link_mem[wr.link_addr] <= wr.link_data;
    end
    key_q <= key_mem[rd_addr];
    // untouched entries read as the initial free chain
    link_q <= link_ok[rd_addr] ? link_mem[rd_addr]
                               : slt_pkg::LINK_W'(rd_addr) + slt_pkg::LINK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_ok <= '0;
    end else if (wr.link_we) begin
      link_ok[wr.link_addr] <= 1'b1;
    end
  end

endmodule

FILE: src/sorted_linked_table_with_free_list_top.sv
// sorted linked table with free list: control sequencer and result register
//
// channel | signals                              | direction
// --------+--------------------------------------+----------
// in      | in_valid in_ready func key_value     | to block
// out     | out_valid out_ready status slot_used | from block
//         | element_count                        |
//
// one transaction at a time: an accepted transaction steps through start, a walk over
// the list entries (at most SLOT_COUNT, one per memory read of the key/link port), link1,
// link2 and out for an insert or delete that succeeds; a delete that misses skips the
// link steps, and a full-pool insert goes straight to out.
// the link memory reads as the initial free chain until written.
// the next input is taken while a result waits; a stalled result holds the
// sequencer in its last step.
module sorted_linked_table_with_free_list_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [slt_pkg::KEY_W-1:0]  key_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [5:0]                        slot_used,
  output logic [6:0]                        element_count
);

  slt_pkg::state_t                   state, state_next;
  slt_pkg::func_t                    func_r, func_r_next;
  logic signed [slt_pkg::KEY_W-1:0]  key_r, key_r_next;
  logic [slt_pkg::LINK_W-1:0]        here, here_next;
  logic [slt_pkg::LINK_W-1:0]        prev, prev_next;
  logic [slt_pkg::LINK_W-1:0]        after, after_next;
  logic [slt_pkg::LINK_W-1:0]        free_next, free_next_next;
  logic [slt_pkg::LINK_W-1:0]        free_head, free_head_next;
  logic [slt_pkg::LINK_W-1:0]        list_head, list_head_next;
  logic [slt_pkg::COUNT_W-1:0]       count, count_next;
  slt_pkg::status_t                  res_status, res_status_next;
  logic [slt_pkg::SLOT_W-1:0]        res_slot, res_slot_next;
  logic                              out_valid_next;
  logic [1:0]                        status_next;
  logic [5:0]                        slot_used_next;
  logic [6:0]                        element_count_next;

  logic [slt_pkg::SLOT_W-1:0]        rd_addr;
  slt_pkg::wr_req_t                  wr;
  logic signed [slt_pkg::KEY_W-1:0]  key_q;
  logic [slt_pkg::LINK_W-1:0]        link_q;
  logic [slt_pkg::LINK_W-1:0]        relink;

  slt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .key_q   (key_q),
    .link_q  (link_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= slt_pkg::ST_IDLE;
      free_head     <= '0;
      list_head     <= slt_pkg::NO_SLOT;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      free_head     <= free_head_next;
      list_head     <= list_head_next;
      count         <= count_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_r_next;
    key_r         <= key_r_next;
    here          <= here_next;
    prev          <= prev_next;
    after         <= after_next;
    free_next     <= free_next_next;
    res_status    <= res_status_next;
    res_slot      <= res_slot_next;
    status        <= status_next;
    slot_used     <= slot_used_next;
    element_count <= element_count_next;
  end

  always_comb begin
    state_next         = state;
    func_r_next        = func_r;
    key_r_next         = key_r;
    here_next          = here;
    prev_next          = prev;
    after_next         = after;
    free_next_next     = free_next;
    free_head_next     = free_head;
    list_head_next     = list_head;
    count_next         = count;
    res_status_next    = res_status;
    res_slot_next      = res_slot;
    out_valid_next     = out_valid;
    status_next        = status;
    slot_used_next     = slot_used;
    element_count_next = element_count;
    in_ready           = 1'b0;
    rd_addr            = slt_pkg::SLOT_W'(free_head);
    wr                 = '0;
    relink             = (func_r == slt_pkg::FUNC_INSERT) ? free_head : after;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      slt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = slt_pkg::SLOT_W'(free_head);
        if (in_valid) begin
          func_r_next = slt_pkg::func_t'(func);
          key_r_next  = key_value;
          here_next   = list_head;
          prev_next   = slt_pkg::NO_SLOT;
          if (func == slt_pkg::FUNC_INSERT && !slt_pkg::is_slot(free_head)) begin
            res_status_next = slt_pkg::STAT_FULL;
            res_slot_next   = '0;
            state_next      = slt_pkg::ST_OUT;
          end else begin
            state_next = slt_pkg::ST_START;
          end
        end
      end

      slt_pkg::ST_START: begin
        // link of the free head arrives now
        free_next_next = link_q;
        rd_addr        = slt_pkg::SLOT_W'(list_head);
        if (slt_pkg::is_slot(list_head)) begin
          state_next = slt_pkg::ST_WALK;
        end else if (func_r == slt_pkg::FUNC_INSERT) begin
          state_next = slt_pkg::ST_LINK1;
        end else begin
          res_status_next = slt_pkg::STAT_NOT_FOUND;
          res_slot_next   = '0;
          state_next      = slt_pkg::ST_OUT;
        end
      end

      slt_pkg::ST_WALK: begin
        rd_addr = slt_pkg::SLOT_W'(link_q);
        if (key_q < key_r) begin
          prev_next = here;
          here_next = link_q;
          if (!slt_pkg::is_slot(link_q)) begin
            if (func_r == slt_pkg::FUNC_INSERT) begin
              state_next = slt_pkg::ST_LINK1;
            end else begin
              res_status_next = slt_pkg::STAT_NOT_FOUND;
              res_slot_next   = '0;
              state_next      = slt_pkg::ST_OUT;
            end
          end
        end else begin
          after_next = link_q;
          if (func_r == slt_pkg::FUNC_INSERT || key_q == key_r) begin
            state_next = slt_pkg::ST_LINK1;
          end else begin
            res_status_next = slt_pkg::STAT_NOT_FOUND;
            res_slot_next   = '0;
            state_next      = slt_pkg::ST_OUT;
          end
        end
      end

      slt_pkg::ST_LINK1: begin
        wr.link_we = 1'b1;
        if (func_r == slt_pkg::FUNC_INSERT) begin
          wr.key_we    = 1'b1;
          wr.key_addr  = slt_pkg::SLOT_W'(free_head);
          wr.key_data  = key_r;
          wr.link_addr = slt_pkg::SLOT_W'(free_head);
          wr.link_data = here;
        end else begin
          wr.link_addr = slt_pkg::SLOT_W'(here);
          wr.link_data = free_head;
        end
        state_next = slt_pkg::ST_LINK2;
      end

      slt_pkg::ST_LINK2: begin
        if (slt_pkg::is_slot(prev)) begin
          wr.link_we   = 1'b1;
          wr.link_addr = slt_pkg::SLOT_W'(prev);
          wr.link_data = relink;
        end else begin
          list_head_next = relink;
        end
        res_status_next = slt_pkg::STAT_DONE;
        if (func_r == slt_pkg::FUNC_INSERT) begin
          res_slot_next  = slt_pkg::SLOT_W'(free_head);
          free_head_next = free_next;
          count_next     = count + slt_pkg::COUNT_W'(1);
        end else begin
          res_slot_next  = slt_pkg::SLOT_W'(here);
          free_head_next = here;
          count_next     = count - slt_pkg::COUNT_W'(1);
        end
        state_next = slt_pkg::ST_OUT;
      end

      slt_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next     = 1'b1;
          status_next        = res_status;
          slot_used_next     = 6'(res_slot);
          element_count_next = 7'(count);
          state_next         = slt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = slt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: bench/slt_table_checker.sv
// checker for the sorted linked table: predicts each result from accepted inputs and compares
`timescale 1ns / 100ps

module slt_table_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             func,
  input  logic signed [slt_pkg::KEY_W-1:0] key_value,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       status,
  input  logic [5:0]                       slot_used,
  input  logic [6:0]                       element_count,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    slt_pkg::status_t st;
    logic [5:0]       slot;
    logic [6:0]       count;
  } table_result_t;

  logic signed [slt_pkg::KEY_W-1:0] key_mem [slt_pkg::SLOT_COUNT];
  logic [slt_pkg::LINK_W-1:0]       link_mem [slt_pkg::SLOT_COUNT];
  logic [slt_pkg::LINK_W-1:0]       head_slot;
  logic [slt_pkg::LINK_W-1:0]       free_slot;
  int                               live_keys;
  table_result_t                    awaited_results [$];

  task automatic clear_table();
    for (int i = 0; i < slt_pkg::SLOT_COUNT; i++) begin
      link_mem[i] = (i == slt_pkg::SLOT_COUNT - 1) ? slt_pkg::NO_SLOT
                                                   : slt_pkg::LINK_W'(i + 1);
    end
    head_slot = slt_pkg::NO_SLOT;
    free_slot = '0;
    live_keys = 0;
    awaited_results.delete();
  endtask

  // walk to the first key not below k, then link in or unlink there
  function automatic table_result_t apply_table_op(logic f,
                                                   logic signed [slt_pkg::KEY_W-1:0] k);
    table_result_t              r;
    logic [slt_pkg::LINK_W-1:0] prior;
    logic [slt_pkg::LINK_W-1:0] cur;
    logic [slt_pkg::LINK_W-1:0] fresh;
    int                         steps;
    r.st   = slt_pkg::STAT_DONE;
    r.slot = '0;
    prior  = slt_pkg::NO_SLOT;
    cur    = head_slot;
    steps  = 0;
    while (cur < slt_pkg::NO_SLOT && key_mem[cur[slt_pkg::SLOT_W-1:0]] < k &&
           steps < slt_pkg::SLOT_COUNT) begin
      prior = cur;
      cur   = link_mem[cur[slt_pkg::SLOT_W-1:0]];
      steps++;
    end
    if (f == slt_pkg::FUNC_INSERT) begin
      if (free_slot >= slt_pkg::NO_SLOT) begin
        r.st = slt_pkg::STAT_FULL;
      end else begin
        fresh                                = free_slot;
        free_slot                            = link_mem[fresh[slt_pkg::SLOT_W-1:0]];
        key_mem[fresh[slt_pkg::SLOT_W-1:0]]  = k;
        link_mem[fresh[slt_pkg::SLOT_W-1:0]] = cur;
        if (prior < slt_pkg::NO_SLOT) begin
          link_mem[prior[slt_pkg::SLOT_W-1:0]] = fresh;
        end else begin
          head_slot = fresh;
        end
        live_keys++;
        r.slot = fresh[5:0];
      end
    end else begin
      if (cur >= slt_pkg::NO_SLOT || key_mem[cur[slt_pkg::SLOT_W-1:0]] != k) begin
        r.st = slt_pkg::STAT_NOT_FOUND;
      end else begin
        if (prior < slt_pkg::NO_SLOT) begin
          link_mem[prior[slt_pkg::SLOT_W-1:0]] = link_mem[cur[slt_pkg::SLOT_W-1:0]];
        end else begin
          head_slot = link_mem[cur[slt_pkg::SLOT_W-1:0]];
        end
        link_mem[cur[slt_pkg::SLOT_W-1:0]] = free_slot;
        free_slot                          = cur;
        live_keys--;
        r.slot = cur[5:0];
      end
    end
    r.count = live_keys[6:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      clear_table();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result status %0d slot %0d count %0d",
                     $realtime, status, slot_used, element_count);
          end
        end else begin
          want = awaited_results.pop_front();
          if (status != want.st || slot_used != want.slot || element_count != want.count) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("%0t: bad result: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                       $realtime, want.st, want.slot, want.count,
                       status, slot_used, element_count);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_table_op(func, key_value));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

FILE: bench/tb_top.sv
// testbench top for the sorted linked table: stimulus, idling phases and verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             func = slt_pkg::FUNC_INSERT;
  logic signed [slt_pkg::KEY_W-1:0] key_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [1:0]                       status;
  logic [5:0]                       slot_used;
  logic [6:0]                       element_count;
  int                               fail_count;
  int                               pending;
  int                               cycle_count = 0;
  int                               idle_pct = 0;
  int                               stall_pct = 0;

  // keys believed to be in the table, used to aim deletes and duplicates
  logic signed [slt_pkg::KEY_W-1:0] held_keys [$];
  logic signed [slt_pkg::KEY_W-1:0] key_pool [12] = '{
    32'sh8000_0000, 32'sh8000_0001, -32'sd1000, -32'sd2, -32'sd1, 32'sd0,
    32'sd1, 32'sd2, 32'sd7, 32'sd1000, 32'sh7fff_fffe, 32'sh7fff_ffff
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_linked_table_with_free_list_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .key_value     (key_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_used     (slot_used),
    .element_count (element_count)
  );

  slt_table_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .key_value     (key_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_used     (slot_used),
    .element_count (element_count),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic issue(slt_pkg::func_t f, logic signed [slt_pkg::KEY_W-1:0] k);
    int idx;
    idx = -1;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    key_value <= k;
    do @(posedge clk); while (!in_ready);
    if (f == slt_pkg::FUNC_INSERT) begin
      if (held_keys.size() < slt_pkg::SLOT_COUNT) held_keys.push_back(k);
    end else begin
      for (int i = 0; i < held_keys.size(); i++) begin
        if (idx < 0 && held_keys[i] == k) idx = i;
      end
      if (idx >= 0) held_keys.delete(idx);
    end
  endtask

  task automatic random_item(int insert_pct);
    logic signed [slt_pkg::KEY_W-1:0] k;
    int                               pick;
    pick = $urandom_range(9);
    if ($urandom_range(99) < insert_pct) begin
      if (pick < 5) begin
        k = key_pool[$urandom_range(11)];
      end else if (pick < 7 && held_keys.size() > 0) begin
        k = held_keys[$urandom_range(held_keys.size() - 1)];
      end else begin
        k = $urandom;
      end
      issue(slt_pkg::FUNC_INSERT, k);
    end else begin
      if (pick < 8 && held_keys.size() > 0) begin
        k = held_keys[$urandom_range(held_keys.size() - 1)];
      end else if (pick < 9) begin
        k = key_pool[$urandom_range(11)];
      end else begin
        k = $urandom;
      end
      issue(slt_pkg::FUNC_DELETE, k);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, duplicates, head/middle/tail removal, absent keys, empty table
    issue(slt_pkg::FUNC_DELETE, 32'sd12345);
    issue(slt_pkg::FUNC_INSERT, 32'sh8000_0000);
    issue(slt_pkg::FUNC_INSERT, 32'sh7fff_ffff);
    issue(slt_pkg::FUNC_INSERT, 32'sd0);
    issue(slt_pkg::FUNC_INSERT, -32'sd1);
    issue(slt_pkg::FUNC_INSERT, 32'sd0);
    issue(slt_pkg::FUNC_INSERT, 32'sd1);
    issue(slt_pkg::FUNC_INSERT, 32'sh8000_0000);
    issue(slt_pkg::FUNC_DELETE, 32'sd5);
    issue(slt_pkg::FUNC_DELETE, 32'sh7fff_ffff);
    issue(slt_pkg::FUNC_DELETE, 32'sh8000_0000);
    issue(slt_pkg::FUNC_DELETE, 32'sd0);
    issue(slt_pkg::FUNC_DELETE, 32'sd0);
    issue(slt_pkg::FUNC_DELETE, 32'sd0);
    issue(slt_pkg::FUNC_INSERT, 32'sh5555_5555);
    issue(slt_pkg::FUNC_INSERT, 32'shaaaa_aaaa);
    issue(slt_pkg::FUNC_DELETE, -32'sd1);
    issue(slt_pkg::FUNC_DELETE, 32'sd1);
    issue(slt_pkg::FUNC_DELETE, 32'sh8000_0000);
    issue(slt_pkg::FUNC_DELETE, 32'shaaaa_aaaa);
    issue(slt_pkg::FUNC_DELETE, 32'sh5555_5555);
    issue(slt_pkg::FUNC_DELETE, 32'sh7fff_ffff);

    // alternate fill and drain bursts so the pool goes full and empty
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (int j = 0; j < 340; j++) begin
        if (phase == 0 && j < 85) begin
          random_item(100);
        end else if ((j / 85) % 2 == 0) begin
          random_item(92);
        end else begin
          random_item(10);
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/slt_pkg.sv
src/slt_store.sv
src/sorted_linked_table_with_free_list_top.sv
bench/slt_table_checker.sv
bench/tb_top.sv
